// ===== hw/rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
`default_nettype none
package lr_pkg;

  localparam int COORD_BITS = 6;
  localparam int ACC_BITS   = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } row_dir_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } lr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nonempty;
    logic last;
  } lr_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lr_datapath.sv =====
// Datapath of the line rasterizer: coordinates, accumulator and step logic.
`default_nettype none
module lr_datapath (
  input  wire logic               clk,
  input  wire lr_pkg::lr_cmd_t    cmd,
  input  wire lr_pkg::coord_t     x_start,
  input  wire lr_pkg::coord_t     y_start,
  input  wire lr_pkg::coord_t     x_end,
  input  wire lr_pkg::coord_t     y_end,
  output lr_pkg::lr_status_t      status,
  output lr_pkg::coord_t          pixel_x,
  output lr_pkg::coord_t          pixel_y,
  output logic                    last_pixel
);

  lr_pkg::coord_t   col_r, col_nxt;
  lr_pkg::coord_t   row_r, row_nxt;
  lr_pkg::coord_t   end_r, end_nxt;
  lr_pkg::acc_t     acc_r, acc_nxt;
  lr_pkg::acc_t     inc_r, inc_nxt;
  lr_pkg::acc_t     span_r, span_nxt;
  lr_pkg::row_dir_t dir_r, dir_nxt;

  lr_pkg::acc_t     col_inc;
  lr_pkg::acc_t     acc_sum;
  lr_pkg::acc_t     acc_sub;
  lr_pkg::coord_t   dx_abs;
  lr_pkg::coord_t   dy_abs;

  assign dx_abs = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
  assign dy_abs = (y_end >= y_start) ? y_end - y_start : y_start - y_end;

  assign col_inc = {1'b0, col_r} + lr_pkg::acc_t'(1);
  assign acc_sum = acc_r + inc_r;
  assign acc_sub = acc_sum - span_r;

  assign status.nonempty = (x_end > x_start);
  assign status.last     = (col_inc >= {1'b0, end_r});

  assign pixel_x    = col_r;
  assign pixel_y    = row_r;
  assign last_pixel = status.last;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    end_nxt  = end_r;
    acc_nxt  = acc_r;
    inc_nxt  = inc_r;
    span_nxt = span_r;
    dir_nxt  = dir_r;
    if (cmd.load) begin
      col_nxt  = x_start;
      row_nxt  = y_start;
      end_nxt  = x_end;
      acc_nxt  = '0;
      span_nxt = {1'b0, dx_abs} + lr_pkg::acc_t'(1);
      inc_nxt  = {1'b0, dy_abs} + lr_pkg::acc_t'(1);
      if (y_end > y_start) begin
        dir_nxt = lr_pkg::DIR_INC;
      end else if (y_end < y_start) begin
        dir_nxt = lr_pkg::DIR_DEC;
      end else begin
        dir_nxt = lr_pkg::DIR_HOLD;
      end
    end else if (cmd.step) begin
      col_nxt = col_inc[lr_pkg::COORD_BITS-1:0];
      acc_nxt = acc_sum;
      if (acc_sum >= span_r) begin
        case (dir_r)
          lr_pkg::DIR_INC: row_nxt = row_r + lr_pkg::coord_t'(1);
          lr_pkg::DIR_DEC: row_nxt = row_r - lr_pkg::coord_t'(1);
          default:         row_nxt = row_r;
        endcase
        // Saturate so a steep line keeps stepping one row per column.
        acc_nxt = (acc_sub >= span_r) ? span_r - lr_pkg::acc_t'(1) : acc_sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    end_r  <= end_nxt;
    acc_r  <= acc_nxt;
    inc_r  <= inc_nxt;
    span_r <= span_nxt;
    dir_r  <= dir_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lr_ctrl.sv =====
// Controller state machine of the line rasterizer.
`default_nettype none
module lr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire lr_pkg::lr_status_t status,
  output lr_pkg::lr_cmd_t         cmd,
  output logic                    busy
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;

  assign busy     = (state_r == ST_RUN);
  assign cmd.load = start && (state_r == ST_IDLE);
  assign cmd.step = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load && status.nonempty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/line_rasterizer_unit.sv =====
// Top level of the line rasterizer: controller plus datapath.
//
//   Channel  Ports                                   Handshake
//   request  start, busy, in_x_start..in_y_end       taken when start & !busy
//   pixel    out_valid, out_pixel_x/y, out_last_pixel one-cycle strobe, no stall
//
// A request with in_x_end > in_x_start loads at the accepting edge; its first
// pixel shows in the next cycle, then one per cycle: n = in_x_end - in_x_start
// pixels (up to 63), busy high while they show. An empty request emits nothing.
// busy falls at the edge ending the out_last_pixel cycle; the next request
// is taken once the controller is idle again. Reset holds the controller idle;
// the pixel receiver cannot stall the unit.
`default_nettype none
module line_rasterizer_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire lr_pkg::coord_t in_x_start,
  input  wire lr_pkg::coord_t in_y_start,
  input  wire lr_pkg::coord_t in_x_end,
  input  wire lr_pkg::coord_t in_y_end,
  output logic                out_valid,
  output lr_pkg::coord_t      out_pixel_x,
  output lr_pkg::coord_t      out_pixel_y,
  output logic                out_last_pixel
);

  lr_pkg::lr_cmd_t    cmd;
  lr_pkg::lr_status_t status;

  // Sequence requests: load on accept, advance one column per cycle.
  lr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the line state and step the error accumulator.
  lr_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .status     (status),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .last_pixel (out_last_pixel)
  );

  // Each busy cycle presents exactly one pixel.
  assign out_valid = busy;

endmodule
`default_nettype wire

// ===== hw/rtl/lr_checker.sv =====
// Port-level assertions for the line rasterizer, bound to the top level.
`default_nettype none
module lr_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire lr_pkg::coord_t in_x_start,
  input wire lr_pkg::coord_t in_y_start,
  input wire lr_pkg::coord_t in_x_end,
  input wire logic           out_valid,
  input wire lr_pkg::coord_t out_pixel_x,
  input wire lr_pkg::coord_t out_pixel_y,
  input wire logic           out_last_pixel
);

  a_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_x_end <= in_x_start) |=> !out_valid)
    else $error("empty request produced a pixel");

  a_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_x_end > in_x_start) |=>
      out_valid && (out_pixel_x == $past(in_x_start)) &&
      (out_pixel_y == $past(in_y_start)))
    else $error("first pixel does not match request start");

  a_column_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=>
      out_valid && (out_pixel_x == lr_pkg::coord_t'($past(out_pixel_x) + 1'b1)))
    else $error("pixel run broke or skipped a column");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |=> !out_valid)
    else $error("pixel after last pixel");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("pixel strobe while not busy");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (.*);
`default_nettype wire

// ===== verif/tb_line_rasterizer_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_rasterizer_unit: directed and random line requests.
module tb_line_rasterizer_unit;

  // One pixel as the unit should emit it.
  typedef struct {
    lr_pkg::coord_t x;
    lr_pkg::coord_t y;
    logic           last;
  } pixel_t;

  // Traces each accepted line request into its pixels and checks the
  // emitted pixels against them in order.
  class line_checker;
    pixel_t pending_pixels[$];
    int     errors;
    int     pixels_seen;
    int     reports;

    function new();
      errors      = 0;
      pixels_seen = 0;
      reports     = 0;
    endfunction

    // Walk the columns of one request and queue the pixels it produces.
    function void note_request(lr_pkg::coord_t xs, lr_pkg::coord_t ys,
                               lr_pkg::coord_t xe, lr_pkg::coord_t ye);
      lr_pkg::coord_t              col;
      lr_pkg::coord_t              row;
      lr_pkg::acc_t                acc;
      lr_pkg::acc_t                span;
      lr_pkg::acc_t                rise;
      lr_pkg::row_dir_t            dir;
      logic [lr_pkg::COORD_BITS:0] nxt;
      logic                        run;
      logic                        fin;
      pixel_t                      px;
      col  = xs;
      row  = ys;
      acc  = '0;
      span = {1'b0, (xe >= xs) ? lr_pkg::coord_t'(xe - xs) : lr_pkg::coord_t'(xs - xe)}
             + lr_pkg::acc_t'(1);
      rise = {1'b0, (ye >= ys) ? lr_pkg::coord_t'(ye - ys) : lr_pkg::coord_t'(ys - ye)}
             + lr_pkg::acc_t'(1);
      if (ye > ys) dir = lr_pkg::DIR_INC;
      else if (ye < ys) dir = lr_pkg::DIR_DEC;
      else dir = lr_pkg::DIR_HOLD;
      run = (xe > xs);
      while (run) begin
        nxt     = {1'b0, col} + 1'b1;
        fin     = (nxt >= {1'b0, xe});
        px.x    = col;
        px.y    = row;
        px.last = fin;
        pending_pixels.push_back(px);
        acc = acc + rise;
        if (acc >= span) begin
          if (dir == lr_pkg::DIR_INC) row = row + 1'b1;
          else if (dir == lr_pkg::DIR_DEC) row = row - 1'b1;
          acc = acc - span;
          // saturate so a steep line keeps stepping every column
          if (acc >= span) acc = span - 1'b1;
        end
        col = nxt[lr_pkg::COORD_BITS-1:0];
        if (fin) run = 1'b0;
      end
    endfunction

    // Compare one emitted pixel with the oldest queued one.
    function void check_pixel(lr_pkg::coord_t x, lr_pkg::coord_t y, logic last);
      pixel_t want;
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (reports < 30)
          $display("%0t: unexpected pixel x=%0d y=%0d last=%0b, none expected",
                   $time, x, y, last);
        reports++;
        return;
      end
      want = pending_pixels.pop_front();
      if ({x, y, last} !== {want.x, want.y, want.last}) begin
        errors++;
        if (reports < 30)
          $display("%0t: pixel differs: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $time, want.x, want.y, want.last, x, y, last);
        reports++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  lr_pkg::coord_t in_x_start;
  lr_pkg::coord_t in_y_start;
  lr_pkg::coord_t in_x_end;
  lr_pkg::coord_t in_y_end;
  logic           out_valid;
  lr_pkg::coord_t out_pixel_x;
  lr_pkg::coord_t out_pixel_y;
  logic           out_last_pixel;

  line_checker chk = new();

  int lines_sent;
  int empty_sent;
  int drains;
  bit no_idle;

  // Directed requests, packed as {x_start, y_start, x_end, y_end}.
  localparam int DIRECTED_COUNT = 20;
  localparam logic [23:0] DIRECTED [DIRECTED_COUNT] = '{
    {6'd0,  6'd0,  6'd63, 6'd63},   // full diagonal up
    {6'd0,  6'd63, 6'd63, 6'd0},    // full diagonal down
    {6'd0,  6'd0,  6'd63, 6'd0},    // horizontal at row zero
    {6'd0,  6'd63, 6'd63, 6'd63},   // horizontal at top row
    {6'd0,  6'd0,  6'd1,  6'd63},   // single column, steep
    {6'd0,  6'd63, 6'd2,  6'd0},    // two columns, steep down
    {6'd10, 6'd5,  6'd11, 6'd5},    // single pixel
    {6'd5,  6'd5,  6'd5,  6'd9},    // empty: equal columns
    {6'd63, 6'd0,  6'd0,  6'd63},   // empty: reversed columns
    {6'd63, 6'd63, 6'd63, 6'd63},   // empty: all ones
    {6'd0,  6'd32, 6'd63, 6'd33},   // shallow, one row step
    {6'd20, 6'd40, 6'd24, 6'd0},    // steep down, saturating accumulator
    {6'd0,  6'd0,  6'd63, 6'd1},    // shallow up
    {6'd62, 6'd10, 6'd63, 6'd10},   // last column
    {6'd0,  6'd0,  6'd5,  6'd63},   // steep up
    {6'd30, 6'd30, 6'd40, 6'd20},   // moderate down
    {6'd1,  6'd62, 6'd62, 6'd1},    // long down
    {6'd42, 6'd21, 6'd21, 6'd42},   // empty: reversed
    {6'd0,  6'd0,  6'd32, 6'd32},   // exact diagonal
    {6'd31, 6'd0,  6'd32, 6'd63}    // single pixel mid range
  };

  line_rasterizer_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick an idle gap: mostly none or short, now and then long. Burst
  // stretches force back-to-back requests.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Issue one request. Lower start for the gap (or the drain), then hold the
  // request until an edge with busy low takes it, and note it at that edge.
  task automatic send_line(input lr_pkg::coord_t xs, input lr_pkg::coord_t ys,
                           input lr_pkg::coord_t xe, input lr_pkg::coord_t ye,
                           input int gap, input bit drain);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      @(posedge clk);
      // drain: wait for every queued pixel to arrive before going on
      if (drain) begin
        drains++;
        while (chk.pending_pixels.size() > 0 || busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    @(posedge clk);
    while (busy) @(posedge clk);
    // the request was taken at this edge
    chk.note_request(xs, ys, xe, ye);
    lines_sent++;
    if (!(xe > xs)) empty_sent++;
  endtask

  // Build one random request: mostly short lines, some long, a few empty.
  task automatic random_line(input bit drain);
    int             len;
    int             r;
    lr_pkg::coord_t xs;
    lr_pkg::coord_t ys;
    lr_pkg::coord_t xe;
    lr_pkg::coord_t ye;
    r  = $urandom_range(0, 99);
    ys = lr_pkg::coord_t'($urandom_range(0, 63));
    ye = lr_pkg::coord_t'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) ye = ys;
    if (r < 12) begin
      xs = lr_pkg::coord_t'($urandom_range(0, 63));
      xe = lr_pkg::coord_t'($urandom_range(0, xs));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(1, 8);
      else if (r < 90) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 63);
      xs = lr_pkg::coord_t'($urandom_range(0, 63 - len));
      xe = lr_pkg::coord_t'(xs + len);
    end
    send_line(xs, ys, xe, ye, pick_gap(), drain);
  endtask

  // Check every strobed pixel; sampled at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) chk.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
  end

  initial begin
    int leftover;
    lines_sent = 0;
    empty_sent = 0;
    drains     = 0;
    no_idle    = 1'b0;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_x_start <= '0;
    in_y_start <= '0;
    in_x_end   <= '0;
    in_y_end   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, empty, horizontal and steep lines.
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_line(DIRECTED[i][23:18], DIRECTED[i][17:12], DIRECTED[i][11:6],
                DIRECTED[i][5:0], pick_gap(), 1'b0);

    // Random: let the directed part drain first, then mix bursts and gaps.
    for (int i = 0; i < 400; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_line(i == 0 || $urandom_range(0, 99) < 3);
    end

    // Drop start, wait for the queue to empty, then hold a line's worth of
    // cycles so a stray pixel still gets caught.
    start <= 1'b0;
    while (chk.pending_pixels.size() > 0 || busy) @(posedge clk);
    repeat (70) @(posedge clk);

    leftover = chk.pending_pixels.size();
    if (leftover > 0)
      $display("%0t: %0d expected pixels never arrived", $time, leftover);
    $display("Sent %0d line requests (%0d empty, %0d drain pauses), checked %0d pixels.",
             lines_sent, empty_sent, drains, chk.pixels_seen);
    $display("Lines covered extremes, steep and horizontal cases, with bursts and gaps.");
    if (chk.errors == 0 && leftover == 0) begin
      $display("line_rasterizer_unit: match");
    end else begin
      $display("line_rasterizer_unit: mismatch");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #5000000;
    $display("line_rasterizer_unit: mismatch");
    $finish;
  end

endmodule

// ===== line_rasterizer_unit.f =====
hw/rtl/lr_pkg.sv
hw/rtl/lr_datapath.sv
hw/rtl/lr_ctrl.sv
hw/rtl/line_rasterizer_unit.sv
hw/rtl/lr_checker.sv
verif/tb_line_rasterizer_unit.sv
